// ===== hw/rtl/iosfp_pkg.sv =====
// ----------------------------------------------------------------------------
// iosfp_pkg
// Types and constants shared by the I/O sample frame parser.
// ----------------------------------------------------------------------------
package iosfp_pkg;

    // Frame type bytes
    localparam logic [7:0] TYPE_ADDR64 = 8'h82;
    localparam logic [7:0] TYPE_ADDR16 = 8'h83;

    // Address length in bytes for each frame type
    localparam logic [3:0] ADDR64_BYTES = 4'd8;
    localparam logic [3:0] ADDR16_BYTES = 4'd2;

    // Channel mask layout
    localparam int NUM_DIGITAL    = 9;
    localparam int NUM_ANALOG     = 6;
    localparam int ANALOG_LSB     = 9;
    localparam logic [15:0] DIGITAL_MASK = 16'h01FF;

    // Analog channel index meaning "no more enabled analog channels"
    localparam logic [2:0] ANALOG_NONE = 3'd6;

    // Parse phases; order matters for the range checks at frame end
    typedef enum logic [3:0] {
        PH_TYPE  = 4'd0,
        PH_ADDR  = 4'd1,
        PH_RSSI  = 4'd2,
        PH_OPTS  = 4'd3,
        PH_COUNT = 4'd4,
        PH_MHI   = 4'd5,
        PH_MLO   = 4'd6,
        PH_DHI   = 4'd7,
        PH_DLO   = 4'd8,
        PH_AHI   = 4'd9,
        PH_ALO   = 4'd10,
        PH_DRAIN = 4'd11
    } phase_t;

    // Job opcodes; encoded as the result kind they produce
    typedef enum logic [2:0] {
        OP_HEADER    = 3'd0,
        OP_DIGITAL   = 3'd1,
        OP_ANALOG    = 3'd2,
        OP_BAD_TYPE  = 3'd3,
        OP_SHORT_HDR = 3'd4,
        OP_TRUNC     = 3'd5
    } op_t;

    // One job handed from the front end to the back end
    typedef struct packed {
        op_t         op;
        logic        tail_trunc;   // append a truncation result after the job
        logic [63:0] addr;
        logic        addr_long;
        logic [7:0]  rssi;
        logic [7:0]  opts;
        logic [9:0]  value;        // digital word or analog reading
        logic [3:0]  chan;         // analog channel
        logic [8:0]  dmask;        // enabled digital channels
    } job_t;

endpackage

// ===== hw/rtl/iosfp_byte_if.sv =====
// ----------------------------------------------------------------------------
// iosfp_byte_if
// Byte stream channel: one payload byte per beat plus end-of-frame flag.
// ----------------------------------------------------------------------------
interface iosfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       frame_end;

    modport source (output valid, output byte_in, output frame_end, input ready);
    modport sink   (input valid, input byte_in, input frame_end, output ready);
endinterface

// ===== hw/rtl/iosfp_result_if.sv =====
// ----------------------------------------------------------------------------
// iosfp_result_if
// Result channel: one parsed result per beat.
// ----------------------------------------------------------------------------
interface iosfp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [9:0]  sample_value;
    logic [63:0] source_address;
    logic        address_long;
    logic [7:0]  rssi;
    logic [7:0]  rx_options;
    logic        last_of_run;

    modport source (
        output valid, output kind, output channel, output sample_value,
        output source_address, output address_long, output rssi,
        output rx_options, output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input channel, input sample_value,
        input source_address, input address_long, input rssi,
        input rx_options, input last_of_run, output ready
    );
endinterface

// ===== hw/rtl/iosfp_front.sv =====
// ----------------------------------------------------------------------------
// iosfp_front
// Frame parser: walks the header and sample layout, one byte per beat,
// and issues a job for every byte that causes results.
// ----------------------------------------------------------------------------
module iosfp_front (
    input  logic              clk,
    input  logic              rst_n,
    iosfp_byte_if.sink        frame,
    input  logic              job_room,
    output logic              job_push,
    output iosfp_pkg::job_t   job
);

    iosfp_pkg::phase_t phase_reg, phase_next;
    logic [63:0] addr_reg, addr_next;
    logic        long_reg, long_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  rssi_reg, rssi_next;
    logic [7:0]  samples_reg, samples_next;
    logic [15:0] mask_reg, mask_next;
    logic [7:0]  hi_reg, hi_next;
    logic [2:0]  aidx_reg, aidx_next;

    logic        accept;
    logic        job_valid;
    logic [15:0] mask_lo;
    logic [7:0]  samples_dec;
    logic [3:0]  cnt_dec;
    logic [2:0]  a_first;
    logic [2:0]  a_first_new;
    logic [2:0]  a_after;
    logic        has_digital;
    iosfp_pkg::phase_t phase_body;

    // Lowest enabled analog channel at or above 'from'; ANALOG_NONE if none
    function automatic logic [2:0] next_analog(input logic [5:0] en, input logic [2:0] from);
        logic [2:0] res;
        logic       found;
        res   = iosfp_pkg::ANALOG_NONE;
        found = 1'b0;
        for (int i = 0; i < iosfp_pkg::NUM_ANALOG; i++)
        begin
            if (!found && (3'(i) >= from) && en[i])
            begin
                res   = 3'(i);
                found = 1'b1;
            end
        end
        return res;
    endfunction

    assign accept      = frame.valid && frame.ready;
    assign frame.ready = job_room;
    assign job_push    = accept && job_valid;

    assign mask_lo     = {mask_reg[15:8], frame.byte_in};
    assign samples_dec = samples_reg - 8'd1;
    assign cnt_dec     = cnt_reg - 4'd1;
    assign has_digital = (mask_reg & iosfp_pkg::DIGITAL_MASK) != 16'd0;
    assign a_first     = next_analog(mask_reg[14:9], 3'd0);
    assign a_first_new = next_analog(mask_lo[14:9], 3'd0);
    assign a_after     = next_analog(mask_reg[14:9], aidx_reg + 3'd1);

    always_comb
    begin
        addr_next    = addr_reg;
        long_next    = long_reg;
        cnt_next     = cnt_reg;
        rssi_next    = rssi_reg;
        samples_next = samples_reg;
        mask_next    = mask_reg;
        hi_next      = hi_reg;
        aidx_next    = aidx_reg;
        phase_body   = phase_reg;
        phase_next   = phase_reg;

        job_valid      = 1'b0;
        job            = '0;
        job.op         = iosfp_pkg::OP_HEADER;
        job.addr       = addr_reg;
        job.addr_long  = long_reg;
        job.rssi       = rssi_reg;
        job.opts       = frame.byte_in;
        job.dmask      = mask_reg[8:0];
        job.chan       = {1'b0, aidx_reg};
        job.value      = {1'b0, hi_reg[0], frame.byte_in};

        unique case (phase_reg)
            iosfp_pkg::PH_TYPE:
            begin
                addr_next = '0;
                if (frame.byte_in == iosfp_pkg::TYPE_ADDR64)
                begin
                    long_next  = 1'b1;
                    cnt_next   = iosfp_pkg::ADDR64_BYTES;
                    phase_body = iosfp_pkg::PH_ADDR;
                end
                else if (frame.byte_in == iosfp_pkg::TYPE_ADDR16)
                begin
                    long_next  = 1'b0;
                    cnt_next   = iosfp_pkg::ADDR16_BYTES;
                    phase_body = iosfp_pkg::PH_ADDR;
                end
                else
                begin
                    job_valid  = 1'b1;
                    job.op     = iosfp_pkg::OP_BAD_TYPE;
                    phase_body = iosfp_pkg::PH_DRAIN;
                end
            end
            iosfp_pkg::PH_ADDR:
            begin
                addr_next = {addr_reg[55:0], frame.byte_in};
                cnt_next  = cnt_dec;
                if (cnt_dec == 4'd0)
                    phase_body = iosfp_pkg::PH_RSSI;
            end
            iosfp_pkg::PH_RSSI:
            begin
                rssi_next  = frame.byte_in;
                phase_body = iosfp_pkg::PH_OPTS;
            end
            iosfp_pkg::PH_OPTS:
            begin
                job_valid  = 1'b1;
                job.op     = iosfp_pkg::OP_HEADER;
                phase_body = iosfp_pkg::PH_COUNT;
            end
            iosfp_pkg::PH_COUNT:
            begin
                samples_next = frame.byte_in;
                phase_body   = iosfp_pkg::PH_MHI;
            end
            iosfp_pkg::PH_MHI:
            begin
                mask_next  = {frame.byte_in, 8'd0};
                phase_body = iosfp_pkg::PH_MLO;
            end
            iosfp_pkg::PH_MLO:
            begin
                mask_next = mask_lo;
                if (samples_reg == 8'd0 || mask_lo[14:0] == 15'd0)
                    phase_body = iosfp_pkg::PH_DRAIN;
                else if ((mask_lo & iosfp_pkg::DIGITAL_MASK) != 16'd0)
                    phase_body = iosfp_pkg::PH_DHI;
                else
                begin
                    aidx_next  = a_first_new;
                    phase_body = iosfp_pkg::PH_AHI;
                end
            end
            iosfp_pkg::PH_DHI:
            begin
                hi_next    = frame.byte_in;
                phase_body = iosfp_pkg::PH_DLO;
            end
            iosfp_pkg::PH_AHI:
            begin
                hi_next    = frame.byte_in;
                phase_body = iosfp_pkg::PH_ALO;
            end
            iosfp_pkg::PH_DLO:
            begin
                job_valid = 1'b1;
                job.op    = iosfp_pkg::OP_DIGITAL;
                if (a_first != iosfp_pkg::ANALOG_NONE)
                begin
                    aidx_next  = a_first;
                    phase_body = iosfp_pkg::PH_AHI;
                end
                else
                begin
                    samples_next = samples_dec;
                    if (samples_dec == 8'd0 || !has_digital)
                        phase_body = iosfp_pkg::PH_DRAIN;
                    else
                        phase_body = iosfp_pkg::PH_DHI;
                end
            end
            iosfp_pkg::PH_ALO:
            begin
                job_valid = 1'b1;
                job.op    = iosfp_pkg::OP_ANALOG;
                job.value = {hi_reg[1:0], frame.byte_in};
                if (a_after != iosfp_pkg::ANALOG_NONE)
                begin
                    aidx_next  = a_after;
                    phase_body = iosfp_pkg::PH_AHI;
                end
                else
                begin
                    samples_next = samples_dec;
                    if (samples_dec == 8'd0)
                        phase_body = iosfp_pkg::PH_DRAIN;
                    else if (has_digital)
                        phase_body = iosfp_pkg::PH_DHI;
                    else if (a_first != iosfp_pkg::ANALOG_NONE)
                    begin
                        aidx_next  = a_first;
                        phase_body = iosfp_pkg::PH_AHI;
                    end
                    else
                        phase_body = iosfp_pkg::PH_DRAIN;
                end
            end
            default:
            begin
                phase_body = iosfp_pkg::PH_DRAIN;
            end
        endcase

        phase_next = phase_body;

        // End of frame: flag short header or truncated samples
        if (frame.frame_end)
        begin
            phase_next = iosfp_pkg::PH_TYPE;
            if (phase_body >= iosfp_pkg::PH_ADDR && phase_body <= iosfp_pkg::PH_OPTS)
            begin
                job_valid = 1'b1;
                job.op    = iosfp_pkg::OP_SHORT_HDR;
            end
            else if (phase_body >= iosfp_pkg::PH_COUNT && phase_body <= iosfp_pkg::PH_ALO)
            begin
                if (phase_reg == iosfp_pkg::PH_DLO || !job_valid)
                begin
                    // cut digital word (its results are dropped) or no other job: the flag is the job
                    job_valid = 1'b1;
                    job.op    = iosfp_pkg::OP_TRUNC;
                end
                else
                    job.tail_trunc = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= iosfp_pkg::PH_TYPE;
            addr_reg    <= '0;
            long_reg    <= 1'b0;
            cnt_reg     <= '0;
            rssi_reg    <= '0;
            samples_reg <= '0;
            mask_reg    <= '0;
            hi_reg      <= '0;
            aidx_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            addr_reg    <= addr_next;
            long_reg    <= long_next;
            cnt_reg     <= cnt_next;
            rssi_reg    <= rssi_next;
            samples_reg <= samples_next;
            mask_reg    <= mask_next;
            hi_reg      <= hi_next;
            aidx_reg    <= aidx_next;
        end
    end

endmodule

// ===== hw/rtl/iosfp_job_fifo.sv =====
// ----------------------------------------------------------------------------
// iosfp_job_fifo
// Small job queue between front end and back end.
// ----------------------------------------------------------------------------
module iosfp_job_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iosfp_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output iosfp_pkg::job_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    iosfp_pkg::job_t slots [DEPTH];

    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = cnt_reg == FULL_CNT;
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == LAST_SLOT) ? '0 : wr_reg + AW'(1);
        if (do_pop)
            rd_next = (rd_reg == LAST_SLOT) ? '0 : rd_reg + AW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/iosfp_back.sv =====
// ----------------------------------------------------------------------------
// iosfp_back
// Result generator: expands each job into results, one per cycle unless
// the output is stalled, into an output register.
// ----------------------------------------------------------------------------
module iosfp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_empty,
    input  iosfp_pkg::job_t  job_head,
    output logic             job_pop,
    iosfp_result_if.source   result
);

    logic            busy_reg, busy_next;
    iosfp_pkg::job_t cur_reg;
    logic [8:0]      rem_reg, rem_next;
    logic            tail_reg, tail_next;

    logic            out_valid_reg;
    logic [2:0]      kind_reg;
    logic [3:0]      chan_reg;
    logic [9:0]      value_reg;
    logic [63:0]     addr_reg;
    logic            long_reg;
    logic [7:0]      rssi_reg;
    logic [7:0]      opts_reg;
    logic            last_reg;

    logic            slot_free;
    logic            step;
    logic            load;
    logic            done;
    logic            main_last;
    logic [8:0]      low_bit;
    logic [3:0]      low_idx;
    logic [2:0]      r_kind;
    logic [3:0]      r_chan;
    logic [9:0]      r_value;
    logic            r_last;
    logic            r_is_header;

    assign slot_free = !out_valid_reg || result.ready;
    assign step      = busy_reg && slot_free;

    // lowest pending digital channel
    assign low_bit = rem_reg & (~rem_reg + 9'd1);
    always_comb
    begin
        low_idx = '0;
        for (int i = iosfp_pkg::NUM_DIGITAL - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
                low_idx = 4'(i);
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        tail_next = tail_reg;
        r_kind    = cur_reg.op;
        r_chan    = '0;
        r_value   = '0;
        main_last = 1'b1;
        case (cur_reg.op)
            iosfp_pkg::OP_DIGITAL:
            begin
                r_chan    = low_idx;
                r_value   = {9'd0, cur_reg.value[low_idx]};
                rem_next  = rem_reg & ~low_bit;
                main_last = (rem_reg & ~low_bit) == 9'd0;
            end
            iosfp_pkg::OP_ANALOG:
            begin
                r_chan  = cur_reg.chan;
                r_value = cur_reg.value;
            end
            default:
            begin
            end
        endcase

        if (tail_reg)
        begin
            r_kind  = iosfp_pkg::OP_TRUNC;
            r_chan  = '0;
            r_value = '0;
            r_last  = 1'b1;
        end
        else
        begin
            r_last = main_last && !cur_reg.tail_trunc;
            if (main_last && cur_reg.tail_trunc)
                tail_next = 1'b1;
        end
        done = r_last;
    end

    assign r_is_header = !tail_reg && (cur_reg.op == iosfp_pkg::OP_HEADER);
    assign load        = !job_empty && (!busy_reg || (step && done));
    assign job_pop     = load;

    always_comb
    begin
        busy_next = busy_reg;
        if (load)
            busy_next = 1'b1;
        else if (step && done)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (step)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg  <= job_head;
            rem_reg  <= job_head.dmask;
            tail_reg <= 1'b0;
        end
        else if (step)
        begin
            rem_reg  <= rem_next;
            tail_reg <= tail_next;
        end

        if (step)
        begin
            kind_reg  <= r_kind;
            chan_reg  <= r_chan;
            value_reg <= r_value;
            addr_reg  <= r_is_header ? cur_reg.addr : 64'd0;
            long_reg  <= r_is_header ? cur_reg.addr_long : 1'b0;
            rssi_reg  <= r_is_header ? cur_reg.rssi : 8'd0;
            opts_reg  <= r_is_header ? cur_reg.opts : 8'd0;
            last_reg  <= r_last;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = kind_reg;
    assign result.channel        = chan_reg;
    assign result.sample_value   = value_reg;
    assign result.source_address = addr_reg;
    assign result.address_long   = long_reg;
    assign result.rssi           = rssi_reg;
    assign result.rx_options     = opts_reg;
    assign result.last_of_run    = last_reg;

endmodule

// ===== hw/rtl/io_sample_frame_parser.sv =====
// ----------------------------------------------------------------------------
// io_sample_frame_parser
// Parses I/O sample frame payloads into header, sample and error results.
// ----------------------------------------------------------------------------
// The block takes one payload byte per beat on 'frame' and emits results on
// 'result'. A front-end parser accepts a byte every cycle as long as the job
// queue (JOB_DEPTH entries) has room; bytes that cause results push one job.
// The back end turns a job into results at one result per cycle while the
// output is not stalled, so the sustained rate is set by that expansion: a
// digital word byte gives one result per enabled digital channel (up to
// nine; a word cut by the frame end gives only the truncation flag), every
// other result-bearing byte one or two, and all other bytes none. A byte's
// first result passes through the job queue, the back end's job register and
// the output register. last_of_run marks the final result of a byte.
// ----------------------------------------------------------------------------
module io_sample_frame_parser #(
    parameter int JOB_DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    iosfp_byte_if.sink     frame,
    iosfp_result_if.source result
);

    iosfp_pkg::job_t push_job;
    iosfp_pkg::job_t head_job;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    // header walk and sample layout tracking
    iosfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame),
        .job_room (!full),
        .job_push (push),
        .job      (push_job)
    );

    // decouples byte intake from result expansion
    iosfp_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head_job)
    );

    // one result per cycle into the output register while it is not stalled
    iosfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (empty),
        .job_head  (head_job),
        .job_pop   (pop),
        .result    (result)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for io_sample_frame_parser. A queue of byte beats,
// filled up front with directed frames, shaped random frames and noise,
// feeds a falling-edge driver. A rising-edge monitor runs every accepted
// beat through a bit-accurate parser model and checks each result beat
// against the oldest expected one. Sender gaps and receiver stalls vary by
// phase.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_BEATS = 390;     // random stimulus length in beats
    localparam int CYCLE_LIMIT  = 200000;  // hard stop for a hung run
    localparam int DRAIN_CYCLES = 40;      // quiet time after the last result

    // Idle profiles, one per stimulus phase
    localparam logic [1:0] MODE_FREE  = 2'd0;  // no gaps, no stalls
    localparam logic [1:0] MODE_SGAP  = 2'd1;  // sender idle half the time
    localparam logic [1:0] MODE_RSTL  = 2'd2;  // receiver stalls half the time
    localparam logic [1:0] MODE_BOTH  = 2'd3;  // both, 16 percent each

    // One queued input beat plus the idle profile it is sent under
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic [1:0] mode;
        logic       hold;     // wait for all results before sending
    } frame_beat_t;

    // One result beat as the block should produce it
    typedef struct packed {
        iosfp_pkg::op_t kind;
        logic [3:0]     channel;
        logic [9:0]     value;
        logic [63:0]    addr;
        logic           along;
        logic [7:0]     rssi;
        logic [7:0]     opts;
        logic           last;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n;

    iosfp_byte_if   byte_ch ();
    iosfp_result_if res_ch ();

    io_sample_frame_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (byte_ch),
        .result (res_ch)
    );

    // 20-unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    frame_beat_t   pending_beats[$];
    parse_result_t expected_results[$];

    int issued_beats   = 0;   // beats put on the bus (driver side)
    int accepted_beats = 0;   // beats taken by the block (monitor side)
    int results_seen   = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int frames_built   = 0;
    int kind_seen [0:7];

    // Stimulus generation state
    logic [1:0] gen_mode   = MODE_FREE;
    logic       gen_hold   = 1'b0;
    int         random_beats = 0;

    // ------------------------------------------------------------------------
    // Parser model state, mirrors the block's registers
    // ------------------------------------------------------------------------
    iosfp_pkg::phase_t ps_phase;
    logic [63:0] ps_addr;
    logic        ps_long;
    logic [3:0]  ps_addr_left;
    logic [7:0]  ps_rssi;
    logic [7:0]  ps_samples;
    logic [15:0] ps_mask;
    logic [7:0]  ps_high;
    logic [2:0]  ps_aidx;

    task automatic reset_parser_model();
        ps_phase     = iosfp_pkg::PH_TYPE;
        ps_addr      = '0;
        ps_long      = 1'b0;
        ps_addr_left = '0;
        ps_rssi      = '0;
        ps_samples   = '0;
        ps_mask      = '0;
        ps_high      = '0;
        ps_aidx      = '0;
    endtask

    // Lowest enabled analog channel at or above 'from', ANALOG_NONE if none
    function automatic logic [2:0] next_analog(input logic [15:0] mask, input int from);
        next_analog = iosfp_pkg::ANALOG_NONE;
        for (int i = iosfp_pkg::NUM_ANALOG - 1; i >= from; i--)
            if (mask[iosfp_pkg::ANALOG_LSB + i])
                next_analog = 3'(i);
    endfunction

    function automatic parse_result_t plain_result(input iosfp_pkg::op_t k,
                                                   input logic [3:0] ch,
                                                   input logic [9:0] v);
        parse_result_t r;
        r         = '0;
        r.kind    = k;
        r.channel = ch;
        r.value   = v;
        return r;
    endfunction

    // Pick the first reading of a new sample
    task automatic start_sample();
        logic [2:0] a;
        if (|(ps_mask & iosfp_pkg::DIGITAL_MASK))
            ps_phase = iosfp_pkg::PH_DHI;
        else
        begin
            a = next_analog(ps_mask, 0);
            if (a != iosfp_pkg::ANALOG_NONE)
            begin
                ps_aidx  = a;
                ps_phase = iosfp_pkg::PH_AHI;
            end
            else
                ps_phase = iosfp_pkg::PH_DRAIN;
        end
    endtask

    // After a digital word (from = 0) or an analog reading (from = index + 1)
    task automatic finish_reading(input int from);
        logic [2:0] a;
        a = next_analog(ps_mask, from);
        if (a != iosfp_pkg::ANALOG_NONE)
        begin
            ps_aidx  = a;
            ps_phase = iosfp_pkg::PH_AHI;
        end
        else
        begin
            ps_samples = ps_samples - 8'd1;
            if (ps_samples == 8'd0)
                ps_phase = iosfp_pkg::PH_DRAIN;
            else
                start_sample();
        end
    endtask

    // Advance the model by one accepted beat and queue the results it causes
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        parse_result_t     run[$];
        parse_result_t     hdr;
        iosfp_pkg::phase_t was;
        logic [8:0]        dword;
        logic [9:0]        aword;
        was = ps_phase;
        case (ps_phase)
            iosfp_pkg::PH_TYPE:
            begin
                ps_addr = '0;
                if (b == iosfp_pkg::TYPE_ADDR64)
                begin
                    ps_long      = 1'b1;
                    ps_addr_left = iosfp_pkg::ADDR64_BYTES;
                    ps_phase     = iosfp_pkg::PH_ADDR;
                end
                else if (b == iosfp_pkg::TYPE_ADDR16)
                begin
                    ps_long      = 1'b0;
                    ps_addr_left = iosfp_pkg::ADDR16_BYTES;
                    ps_phase     = iosfp_pkg::PH_ADDR;
                end
                else
                begin
                    run.push_back(plain_result(iosfp_pkg::OP_BAD_TYPE, 4'd0, 10'd0));
                    ps_phase = iosfp_pkg::PH_DRAIN;
                end
            end
            iosfp_pkg::PH_ADDR:
            begin
                ps_addr      = {ps_addr[55:0], b};
                ps_addr_left = ps_addr_left - 4'd1;
                if (ps_addr_left == 4'd0)
                    ps_phase = iosfp_pkg::PH_RSSI;
            end
            iosfp_pkg::PH_RSSI:
            begin
                ps_rssi  = b;
                ps_phase = iosfp_pkg::PH_OPTS;
            end
            iosfp_pkg::PH_OPTS:
            begin
                hdr       = '0;
                hdr.kind  = iosfp_pkg::OP_HEADER;
                hdr.addr  = ps_addr;
                hdr.along = ps_long;
                hdr.rssi  = ps_rssi;
                hdr.opts  = b;
                run.push_back(hdr);
                ps_phase = iosfp_pkg::PH_COUNT;
            end
            iosfp_pkg::PH_COUNT:
            begin
                ps_samples = b;
                ps_phase   = iosfp_pkg::PH_MHI;
            end
            iosfp_pkg::PH_MHI:
            begin
                ps_mask  = {b, 8'd0};
                ps_phase = iosfp_pkg::PH_MLO;
            end
            iosfp_pkg::PH_MLO:
            begin
                ps_mask = ps_mask | {8'd0, b};
                // zero count or nothing enabled: no samples to parse
                if (ps_samples == 8'd0 || (ps_mask & 16'h7FFF) == 16'd0)
                    ps_phase = iosfp_pkg::PH_DRAIN;
                else
                    start_sample();
            end
            iosfp_pkg::PH_DHI:
            begin
                ps_high  = b;
                ps_phase = iosfp_pkg::PH_DLO;
            end
            iosfp_pkg::PH_AHI:
            begin
                ps_high  = b;
                ps_phase = iosfp_pkg::PH_ALO;
            end
            iosfp_pkg::PH_DLO:
            begin
                // only bit 0 of the high byte carries a channel (D8)
                dword = {ps_high[0], b};
                for (int ch = 0; ch < iosfp_pkg::NUM_DIGITAL; ch++)
                    if (ps_mask[ch])
                        run.push_back(plain_result(iosfp_pkg::OP_DIGITAL, 4'(ch),
                                                   {9'd0, dword[ch]}));
                finish_reading(0);
            end
            iosfp_pkg::PH_ALO:
            begin
                // two high bits make the 10-bit reading
                aword = {ps_high[1:0], b};
                run.push_back(plain_result(iosfp_pkg::OP_ANALOG, {1'b0, ps_aidx}, aword));
                finish_reading(ps_aidx + 1);
            end
            default:
                ps_phase = iosfp_pkg::PH_DRAIN;
        endcase

        if (fin)
        begin
            if (ps_phase >= iosfp_pkg::PH_ADDR && ps_phase <= iosfp_pkg::PH_OPTS)
                run.push_back(plain_result(iosfp_pkg::OP_SHORT_HDR, 4'd0, 10'd0));
            else if (ps_phase >= iosfp_pkg::PH_COUNT && ps_phase <= iosfp_pkg::PH_ALO)
            begin
                // a digital word cut short by the frame end yields only the flag
                if (was == iosfp_pkg::PH_DLO)
                    run.delete();
                run.push_back(plain_result(iosfp_pkg::OP_TRUNC, 4'd0, 10'd0));
            end
            ps_phase = iosfp_pkg::PH_TYPE;
        end

        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            expected_results.push_back(run[i]);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_beat(input logic [7:0] data, input logic fin);
        frame_beat_t fb;
        fb.data = data;
        fb.fin  = fin;
        fb.mode = gen_mode;
        fb.hold = gen_hold;
        gen_hold = 1'b0;
        pending_beats.push_back(fb);
    endtask

    // Well-formed frame with random content; optionally cut short or padded.
    // Only the first three samples are laid out, so larger counts end truncated.
    task automatic send_frame(input logic long_addr, input logic [7:0] count,
                              input logic [15:0] mask, input logic cut, input int extra);
        logic [7:0] fb[$];
        int n_samples;
        int n;
        fb.push_back(long_addr ? iosfp_pkg::TYPE_ADDR64 : iosfp_pkg::TYPE_ADDR16);
        repeat (long_addr ? 8 : 2)
            fb.push_back(8'($urandom_range(255)));
        fb.push_back(8'($urandom_range(255)));    // rssi
        fb.push_back(8'($urandom_range(255)));    // options
        fb.push_back(count);
        fb.push_back(mask[15:8]);
        fb.push_back(mask[7:0]);
        n_samples = (count > 8'd3) ? 3 : int'(count);
        if ((mask & 16'h7FFF) != 16'd0)
            repeat (n_samples)
            begin
                if (|(mask & iosfp_pkg::DIGITAL_MASK))
                    repeat (2)
                        fb.push_back(8'($urandom_range(255)));
                for (int c = 0; c < iosfp_pkg::NUM_ANALOG; c++)
                    if (mask[iosfp_pkg::ANALOG_LSB + c])
                        repeat (2)
                            fb.push_back(8'($urandom_range(255)));
            end
        repeat (extra)
            fb.push_back(8'($urandom_range(255)));
        n = cut ? $urandom_range(1, fb.size()) : fb.size();
        for (int i = 0; i < n; i++)
            push_beat(fb[i], i == n - 1);
        frames_built++;
    endtask

    function automatic logic [15:0] random_mask();
        case ($urandom_range(5))
            0: random_mask = 16'($urandom_range(16'hFFFF));
            1: random_mask = 16'($urandom & $urandom);                  // sparse
            2: random_mask = 16'($urandom_range(16'h01FF));             // digital only
            3: random_mask = {1'($urandom_range(1)), 6'($urandom_range(63)), 9'd0};
            4: random_mask = 16'd1 << $urandom_range(15);               // one bit
            default: random_mask = $urandom_range(1) ? 16'h8000 : 16'h0000;
        endcase
    endfunction

    function automatic logic [7:0] random_count();
        case ($urandom_range(19))
            0: random_count = 8'd0;
            1: random_count = 8'($urandom_range(4, 255));
            default: random_count = 8'($urandom_range(1, 3));
        endcase
    endfunction

    // Field compare with a line per mismatch
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: falling edge. A beat stays on the bus until the monitor has
    // counted it as accepted; then the next one goes out unless the idle
    // profile asks for a gap or the beat is marked to wait for a drain.
    // Receiver ready is rolled here too, so all inputs move on the same edge.
    // ------------------------------------------------------------------------
    logic [1:0] cur_mode = MODE_FREE;

    always @(negedge clk)
    begin : drive_blk
        frame_beat_t it;
        logic        go;
        int          gap_pct;
        int          stall_pct;
        if (rst_n)
        begin
            if (!byte_ch.valid || accepted_beats == issued_beats)
            begin
                go = 1'b0;
                if (pending_beats.size() > 0)
                begin
                    it      = pending_beats[0];
                    gap_pct = (it.mode == MODE_SGAP) ? 50 : (it.mode == MODE_BOTH) ? 16 : 0;
                    if (it.hold && expected_results.size() != 0)
                        go = 1'b0;                      // hold off until drained
                    else
                        go = ($urandom_range(99) >= gap_pct);
                end
                if (go)
                begin
                    it = pending_beats.pop_front();
                    byte_ch.byte_in   <= it.data;
                    byte_ch.frame_end <= it.fin;
                    cur_mode = it.mode;
                    issued_beats++;
                end
                byte_ch.valid <= go;
            end
            stall_pct = (cur_mode == MODE_RSTL) ? 50 : (cur_mode == MODE_BOTH) ? 16 : 0;
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: rising edge. Accepted input beats go through the model first,
    // then any accepted result beat is checked against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_blk
        parse_result_t got;
        parse_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                parse_byte(byte_ch.byte_in, byte_ch.frame_end);
                accepted_beats++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.kind    = iosfp_pkg::op_t'(res_ch.kind);
                got.channel = res_ch.channel;
                got.value   = res_ch.sample_value;
                got.addr    = res_ch.source_address;
                got.along   = res_ch.address_long;
                got.rssi    = res_ch.rssi;
                got.opts    = res_ch.rx_options;
                got.last    = res_ch.last_of_run;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, %s %0d ch %0d val %0h",
                             $time, "got kind", got.kind, got.channel, got.value);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("channel", want.channel, got.channel);
                    check_field("sample_value", want.value, got.value);
                    check_field("source_address", want.addr, got.addr);
                    check_field("address_long", want.along, got.along);
                    check_field("rssi", want.rssi, got.rssi);
                    check_field("rx_options", want.opts, got.opts);
                    check_field("last_of_run", want.last, got.last);
                    kind_seen[want.kind]++;
                end
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, fill the beat queue, wait for the drain, report.
    // ------------------------------------------------------------------------
    initial
    begin : main_blk
        int phase_now;
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.byte_in   = 8'd0;
        byte_ch.frame_end = 1'b0;
        res_ch.ready      = 1'b0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        reset_parser_model();

        // Directed frames, no idling
        // bad type byte closing its own frame
        push_beat(8'h00, 1'b1);
        // frame ends right on the type byte: short header
        push_beat(iosfp_pkg::TYPE_ADDR16, 1'b1);
        // ends on the options byte: header then truncation flag
        push_beat(iosfp_pkg::TYPE_ADDR16, 1'b0); push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b0); push_beat(8'hFF, 1'b0); push_beat(8'h00, 1'b1);
        // all nine digital channels, mask bit 15 set but ignored, D8 from high byte
        push_beat(iosfp_pkg::TYPE_ADDR16, 1'b0); push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b0); push_beat(8'h00, 1'b0); push_beat(8'hFF, 1'b0);
        push_beat(8'h01, 1'b0); push_beat(8'h81, 1'b0); push_beat(8'hFF, 1'b0);
        push_beat(8'h01, 1'b0); push_beat(8'hAA, 1'b1);
        // A5 alone at full scale, upper high-byte bits must be dropped
        push_beat(iosfp_pkg::TYPE_ADDR16, 1'b0); push_beat(8'h12, 1'b0);
        push_beat(8'h34, 1'b0); push_beat(8'h80, 1'b0); push_beat(8'h7F, 1'b0);
        push_beat(8'h01, 1'b0); push_beat(8'h40, 1'b0); push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0); push_beat(8'hFF, 1'b1);
        frames_built += 5;

        // Random part: four idle phases, each opening with a full drain
        while (random_beats < RANDOM_BEATS)
        begin
            phase_now = (random_beats * 4) / RANDOM_BEATS;
            if (phase_now > 3)
                phase_now = 3;
            if (2'(phase_now) != gen_mode || random_beats == 0)
            begin
                gen_mode = 2'(phase_now);
                gen_hold = 1'b1;
            end
            phase_now = pending_beats.size();
            if ($urandom_range(9) == 0)
            begin
                // noise: a few arbitrary bytes, the last one closing the frame
                repeat ($urandom_range(2))
                    push_beat(8'($urandom_range(255)), 1'b0);
                push_beat(8'($urandom_range(255)), 1'b1);
                frames_built++;
            end
            else
                send_frame(1'($urandom_range(1)), random_count(), random_mask(),
                           ($urandom_range(3) == 0),
                           ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0);
            random_beats += pending_beats.size() - phase_now;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_beats.size() != 0 || accepted_beats != issued_beats ||
               expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            error_count++;
        end

        $display("Sent %0d beats in %0d frames; checked %0d results in %0d cycles",
                 accepted_beats, frames_built, results_seen, cycle_count);
        $display("  header %0d, digital %0d, analog %0d, bad type %0d, short %0d, trunc %0d",
                 kind_seen[iosfp_pkg::OP_HEADER], kind_seen[iosfp_pkg::OP_DIGITAL],
                 kind_seen[iosfp_pkg::OP_ANALOG], kind_seen[iosfp_pkg::OP_BAD_TYPE],
                 kind_seen[iosfp_pkg::OP_SHORT_HDR], kind_seen[iosfp_pkg::OP_TRUNC]);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
